>>> hw/rtl/smcs_pkg.sv
// Shared constants and types for the stereo microphone channel selector.
// No dependencies; the front, the queue and the top level import this package.
package smcs_pkg;

  localparam int BLOCK_WORDS = 256;
  localparam int POS_W       = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 2 * SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd64;

  // result queue between the front and the back
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);
  localparam int QSUM_W  = QCNT_W + 1;

  typedef enum logic [1:0] {
    CHOICE_NONE  = 2'd0,
    CHOICE_LEFT  = 2'd1,
    CHOICE_RIGHT = 2'd2
  } choice_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono_sample;
    logic                       from_right;
    logic                       end_of_block;
  } mono_item_t;

  typedef struct packed {
    logic       valid;
    mono_item_t item;
  } push_t;

  // absolute value of a signed half; -32768 gives 32768, which still fits
  function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] h);
    logic [SAMPLE_W-1:0] m;
    m = h[SAMPLE_W-1] ? (~h + 1'b1) : h;
    return m;
  endfunction

endpackage

>>> hw/rtl/smcs_in_if.sv
// Input channel: one stereo word per item, valid/ready handshake.
// Stand-alone; used by the front and the top level.
interface smcs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] stereo_word;

  modport source (output valid, output stereo_word, input ready);
  modport sink   (input valid, input stereo_word, output ready);
endinterface

>>> hw/rtl/smcs_out_if.sv
// Output channel: one mono sample with its flags per item, valid/ready handshake.
// Stand-alone; used by the result queue and the top level.
interface smcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mono_sample;
  logic               from_right;
  logic               end_of_block;

  modport source (output valid, output mono_sample, output from_right,
                  output end_of_block, input ready);
  modport sink   (input valid, input mono_sample, input from_right,
                  input end_of_block, output ready);
endinterface

>>> hw/rtl/smcs_front.sv
// Front end: accepts stereo words, keeps the block store and peaks, makes the
// channel decision and pushes replayed samples. Depends on smcs_pkg, smcs_in_if.
module smcs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [15:0]               cfg_wr_data,
  smcs_in_if.sink                   in_ch,
  input  logic [smcs_pkg::QCNT_W-1:0] q_level,
  output smcs_pkg::push_t           push
);
  import smcs_pkg::*;

  logic [WORD_W-1:0]   block_store [BLOCK_WORDS];
  logic [WORD_W-1:0]   rd_data;

  logic [SAMPLE_W-1:0] threshold;
  logic [POS_W-1:0]    pos;
  logic [SAMPLE_W-1:0] peak_l, peak_r;
  choice_t             choice;
  logic                stored_right;
  logic                stored_valid;

  logic                pend_valid;
  logic                pend_right;
  logic                pend_last;

  logic                accept;
  logic                last;
  logic [SAMPLE_W-1:0] lm, rm;
  logic [SAMPLE_W-1:0] peak_l_next, peak_r_next;
  logic                right_louder;
  choice_t             choice_next;

  // room for this item and any item still in the read stage
  assign in_ch.ready = (QSUM_W'(q_level) + QSUM_W'(pend_valid)) < QSUM_W'(Q_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;
  assign last        = (pos == POS_W'(BLOCK_WORDS - 1));

  always_comb begin
    lm           = magnitude(in_ch.stereo_word[WORD_W-1:SAMPLE_W]);
    rm           = magnitude(in_ch.stereo_word[SAMPLE_W-1:0]);
    peak_l_next  = (lm > peak_l) ? lm : peak_l;
    peak_r_next  = (rm > peak_r) ? rm : peak_r;
    right_louder = peak_r_next > peak_l_next;
    choice_next  = choice;
    if (choice == CHOICE_NONE &&
        (peak_l_next > threshold || peak_r_next > threshold)) begin
      choice_next = right_louder ? CHOICE_RIGHT : CHOICE_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      peak_l       <= '0;
      peak_r       <= '0;
      choice       <= CHOICE_NONE;
      stored_right <= 1'b0;
      stored_valid <= 1'b0;
      pend_valid   <= 1'b0;
      pend_right   <= 1'b0;
      pend_last    <= 1'b0;
    end else begin
      pend_valid <= accept && stored_valid;
      if (accept) begin
        pend_right <= stored_right;
        pend_last  <= last;
        if (last) begin
          pos          <= '0;
          peak_l       <= '0;
          peak_r       <= '0;
          choice       <= choice_next;
          stored_right <= (choice_next != CHOICE_NONE) ? (choice_next == CHOICE_RIGHT)
                                                       : right_louder;
          stored_valid <= 1'b1;
        end else begin
          pos    <= pos + 1'b1;
          peak_l <= peak_l_next;
          peak_r <= peak_r_next;
        end
      end
    end
  end

  // read-first: the old word of the previous block comes out as the new one goes in
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data          <= block_store[pos];
      block_store[pos] <= in_ch.stereo_word;
    end
  end

  always_comb begin
    push.valid             = pend_valid;
    push.item.mono_sample  = pend_right ? rd_data[SAMPLE_W-1:0] : rd_data[WORD_W-1:SAMPLE_W];
    push.item.from_right   = pend_right;
    push.item.end_of_block = pend_last;
  end

  a_pend_needs_block: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> stored_valid)
    else $error("replayed item before any block was stored");

  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (pos == '0 && peak_l == '0 && peak_r == '0))
    else $error("block state not cleared after last word");

  a_lock_holds: assert property (@(posedge clk) disable iff (rst)
    (choice != CHOICE_NONE) |=> (choice == $past(choice)))
    else $error("locked channel changed");

endmodule

>>> hw/rtl/smcs_queue.sv
// Back end: short result queue that drives the output channel.
// Depends on smcs_pkg and smcs_out_if.
module smcs_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  smcs_pkg::push_t             push,
  output logic [smcs_pkg::QCNT_W-1:0] level,
  smcs_out_if.source                  out_ch
);
  import smcs_pkg::*;

  mono_item_t        slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic              pop;

  assign pop                 = out_ch.valid && out_ch.ready;
  assign out_ch.valid        = (level != '0);
  assign out_ch.mono_sample  = slots[rd_ptr].mono_sample;
  assign out_ch.from_right   = slots[rd_ptr].from_right;
  assign out_ch.end_of_block = slots[rd_ptr].end_of_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)        rd_ptr <= rd_ptr + 1'b1;
      if (push.valid && !pop)      level <= level + 1'b1;
      else if (!push.valid && pop) level <= level - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (level == QCNT_W'(Q_DEPTH)) |-> (!push.valid || pop))
    else $error("result queue overflow");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QCNT_W'(Q_DEPTH))
    else $error("result queue level out of range");

  a_level_grows: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |=> (level == QCNT_W'($past(level) + 1'b1)))
    else $error("result queue level did not follow a push");

endmodule

>>> hw/rtl/stereo_mic_channel_select_unit.sv
// Stereo microphone channel selector, top level.
// Throughput: one stereo word per cycle while the result queue has room; output
// lags one full block. The sample replayed for a word is offered once it has
// passed the block store read stage and then the four-entry result queue.
// Reset clears position, peaks, lock, queue and threshold (back to 64); the block
// store is not cleared, and nothing is replayed until a whole block is stored.
module stereo_mic_channel_select_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  smcs_in_if.sink     in_ch,
  smcs_out_if.source  out_ch
);
  import smcs_pkg::*;

  push_t             push;
  logic [QCNT_W-1:0] q_level;

  smcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_level     (q_level),
    .push        (push)
  );

  smcs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .level  (q_level),
    .out_ch (out_ch)
  );

endmodule
